// ===== sv/voxel_surface_extract_6conn_core_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef VOXEL_SURFACE_EXTRACT_6CONN_CORE_MACROS_SVH
`define VOXEL_SURFACE_EXTRACT_6CONN_CORE_MACROS_SVH

// Same-cycle implication.
`define VSE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication.
`define VSE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== sv/vse_pkg.sv =====
package vse_pkg;

   localparam int MAX_DIM_DEFAULT = 128;
   localparam int CFG_W           = 8;
   localparam int POS_W           = 7;
   localparam int COUNT_W         = 21;
   localparam int CSR_AW          = 4;
   localparam int CSR_DW          = 32;

   localparam logic [CFG_W-1:0] SIZE_RESET = 8'd128;

   typedef enum logic [1:0] {
      REG_SIZE_X = 2'd0,
      REG_SIZE_Y = 2'd1,
      REG_SIZE_Z = 2'd2
   } csr_reg_type;

   // per-voxel control decoded at the scan position
   typedef struct packed {
      logic judge;       // interior voxel, produces a result
      logic vol_end;     // last voxel of the volume, count restarts after it
      logic last_voxel;  // result for the last interior voxel
   } scan_ctl_type;

endpackage

// ===== sv/voxel_surface_extract_6conn_core.sv =====
// Six-connected surface voxel detector, one occupancy bit per request.
// Throughput: one request per cycle unless rsp stalls, set by the plane memories (one write
// and two reads each). A result is presented on rsp in the cycle after the edge that moves
// its request out of the compute stage.
// Reset (synchronous, active high): scan position, surface count and valid flags clear, sizes
// return to 128; plane memories are not cleared and need no clearing pass.
module voxel_surface_extract_6conn_core #(
   parameter int MAX_DIM = vse_pkg::MAX_DIM_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [0] occupied, [7:1] zero
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [47:0]                   rsp_tdata,   // [6:0] pos_x, [13:7] pos_y,
                                                      // [20:14] pos_z, [41:21] surface_count,
                                                      // [47:42] zero
   output logic                          rsp_tuser,   // [0] is_surface
   output logic                          rsp_tlast,   // end_of_volume
   // configuration
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [vse_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [vse_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [vse_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);

   import vse_pkg::*;

   localparam int DW = $clog2(MAX_DIM+1);
   localparam int PW = $clog2(MAX_DIM);
   localparam int AW = 2*PW;

   // Memory layout: each plane memory is addressed {y, z}.
   //   hi: bit of the newer plane (x-1 while voxel x streams in); overwritten with the
   //       arriving bit, so ahead of the scan it still holds x-1, behind it holds x.
   //   lo: bit of the older plane (x-2 ahead of the scan); overwritten with the x-1
   //       center bit, so behind the scan it holds x-1.
   // Per request at scan position (x,y,z) the window for voxel (x-1,y,z) comes from:
   //   hi[next pos] -> z+1 neighbour; delayed once it is the center, twice z-1
   //   hi[y+1,z]    -> y+1 neighbour
   //   lo[y-1,z]    -> y-1 neighbour (already rewritten this plane)
   //   lo[y,z]      -> x-2 neighbour
   //   arriving bit -> x neighbour

   logic                  restart;
   logic [DW-1:0]         eff_x, eff_y, eff_z;
   logic                  accept;
   logic                  s1_ready;
   logic [PW-1:0]         pos_x, pos_y, pos_z;
   scan_ctl_type          ctl;
   logic [AW-1:0]         addr_here, addr_next, addr_yp, addr_ym;
   logic                  hi_zp, hi_yp, lo_old, lo_ym;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic                  hi_wdata, lo_wdata;
   logic                  is_surface;
   logic [POS_W-1:0]      out_x, out_y, out_z;
   logic [COUNT_W-1:0]    surface_count;
   logic                  end_of_volume;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = s1_ready;

   vse_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .restart (restart),
      .eff_x   (eff_x),
      .eff_y   (eff_y),
      .eff_z   (eff_z)
   );

   // scan position and read addresses of the request being taken
   vse_scan #(
      .MAX_DIM (MAX_DIM)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .accept    (accept),
      .size_x    (eff_x),
      .size_y    (eff_y),
      .size_z    (eff_z),
      .pos_x     (pos_x),
      .pos_y     (pos_y),
      .pos_z     (pos_z),
      .ctl       (ctl),
      .addr_here (addr_here),
      .addr_next (addr_next),
      .addr_yp   (addr_yp),
      .addr_ym   (addr_ym)
   );

   // reads issue on acceptance; writes land when the request leaves the compute stage,
   // always at an entry none of the pending reads touches
   vse_plane_mem #(
      .AW (AW)
   ) u_mem_hi (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (hi_wdata),
      .rd_en    (accept),
      .rd_addr0 (addr_next),
      .rd_addr1 (addr_yp),
      .rd_data0 (hi_zp),
      .rd_data1 (hi_yp)
   );

   vse_plane_mem #(
      .AW (AW)
   ) u_mem_lo (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (lo_wdata),
      .rd_en    (accept),
      .rd_addr0 (addr_here),
      .rd_addr1 (addr_ym),
      .rd_data0 (lo_old),
      .rd_data1 (lo_ym)
   );

   // compute stage, running count and output register
   vse_stencil #(
      .MAX_DIM (MAX_DIM)
   ) u_stencil (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .accept        (accept),
      .s1_ready      (s1_ready),
      .cur           (req_tdata[0]),
      .ctl           (ctl),
      .pos_x         (pos_x),
      .pos_y         (pos_y),
      .pos_z         (pos_z),
      .addr_here     (addr_here),
      .hi_zp         (hi_zp),
      .hi_yp         (hi_yp),
      .lo_old        (lo_old),
      .lo_ym         (lo_ym),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .hi_wdata      (hi_wdata),
      .lo_wdata      (lo_wdata),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .is_surface    (is_surface),
      .out_x         (out_x),
      .out_y         (out_y),
      .out_z         (out_z),
      .surface_count (surface_count),
      .end_of_volume (end_of_volume)
   );

   assign rsp_tdata = {6'b0, surface_count, out_z, out_y, out_x};
   assign rsp_tuser = is_surface;
   assign rsp_tlast = end_of_volume;

endmodule

// ===== sv/vse_plane_mem.sv =====
module vse_plane_mem #(
   parameter int AW = 14
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr0,
   input  logic [AW-1:0] rd_addr1,
   output logic          rd_data0,
   output logic          rd_data1
);

   logic store_ff [0:(1<<AW)-1];
   logic rd0_ff;
   logic rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds while no new request is taken
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd0_ff <= store_ff[rd_addr0];
         rd1_ff <= store_ff[rd_addr1];
      end
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

// ===== sv/vse_csr.sv =====
module vse_csr #(
   parameter int MAX_DIM = vse_pkg::MAX_DIM_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [vse_pkg::CSR_AW-1:0]    paddr,
   input  logic [vse_pkg::CSR_DW-1:0]    pwdata,
   output logic [vse_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready,
   output logic                          restart,
   output logic [$clog2(MAX_DIM+1)-1:0]  eff_x,
   output logic [$clog2(MAX_DIM+1)-1:0]  eff_y,
   output logic [$clog2(MAX_DIM+1)-1:0]  eff_z
);

   import vse_pkg::*;

   localparam int DW = $clog2(MAX_DIM+1);

   logic [CFG_W-1:0] size_x_ff, size_x_in;
   logic [CFG_W-1:0] size_y_ff, size_y_in;
   logic [CFG_W-1:0] size_z_ff, size_z_in;
   logic             wr;
   csr_reg_type      idx;

   // extents are used clamped to 3..MAX_DIM
   function automatic logic [DW-1:0] clamp_size(input logic [CFG_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w < 32'd3) begin
         clamp_size = DW'(3);
      end else if (w > 32'(MAX_DIM)) begin
         clamp_size = DW'(MAX_DIM);
      end else begin
         clamp_size = DW'(w);
      end
   endfunction

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign idx    = csr_reg_type'(paddr[CSR_AW-1:2]);

   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      restart   = 1'b0;
      if (wr) begin
         case (idx)
            REG_SIZE_X: begin
               size_x_in = pwdata[CFG_W-1:0];
               restart   = 1'b1;
            end
            REG_SIZE_Y: begin
               size_y_in = pwdata[CFG_W-1:0];
               restart   = 1'b1;
            end
            REG_SIZE_Z: begin
               size_z_in = pwdata[CFG_W-1:0];
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SIZE_X: prdata = CSR_DW'(size_x_ff);
         REG_SIZE_Y: prdata = CSR_DW'(size_y_ff);
         REG_SIZE_Z: prdata = CSR_DW'(size_z_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
         size_z_ff <= size_z_in;
      end
   end

   assign eff_x = clamp_size(size_x_ff);
   assign eff_y = clamp_size(size_y_ff);
   assign eff_z = clamp_size(size_z_ff);

endmodule

// ===== sv/vse_scan.sv =====
module vse_scan #(
   parameter int MAX_DIM = vse_pkg::MAX_DIM_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            restart,
   input  logic                            accept,
   input  logic [$clog2(MAX_DIM+1)-1:0]    size_x,
   input  logic [$clog2(MAX_DIM+1)-1:0]    size_y,
   input  logic [$clog2(MAX_DIM+1)-1:0]    size_z,
   output logic [$clog2(MAX_DIM)-1:0]      pos_x,
   output logic [$clog2(MAX_DIM)-1:0]      pos_y,
   output logic [$clog2(MAX_DIM)-1:0]      pos_z,
   output vse_pkg::scan_ctl_type           ctl,
   output logic [2*$clog2(MAX_DIM)-1:0]    addr_here,
   output logic [2*$clog2(MAX_DIM)-1:0]    addr_next,
   output logic [2*$clog2(MAX_DIM)-1:0]    addr_yp,
   output logic [2*$clog2(MAX_DIM)-1:0]    addr_ym
);

   import vse_pkg::*;

   localparam int DW = $clog2(MAX_DIM+1);
   localparam int PW = $clog2(MAX_DIM);

   logic [PW-1:0] x_ff, x_in;
   logic [PW-1:0] y_ff, y_in;
   logic [PW-1:0] z_ff, z_in;
   logic [DW-1:0] x_dw, y_dw, z_dw;
   logic          x_end, y_end, z_end;
   logic [PW-1:0] nx, ny, nz;

   assign x_dw = DW'(x_ff);
   assign y_dw = DW'(y_ff);
   assign z_dw = DW'(z_ff);

   assign z_end = z_dw >= size_z - DW'(1);
   assign y_end = y_dw >= size_y - DW'(1);
   assign x_end = x_dw >= size_x - DW'(1);

   always_comb begin
      nz = z_end ? '0 : z_ff + PW'(1);
      ny = y_ff;
      nx = x_ff;
      if (z_end) begin
         ny = y_end ? '0 : y_ff + PW'(1);
         if (y_end) begin
            nx = x_end ? '0 : x_ff + PW'(1);
         end
      end
   end

   always_comb begin
      ctl.judge      = (x_dw >= DW'(2)) && (y_ff != '0) && (y_dw < size_y - DW'(1)) &&
                       (z_ff != '0) && (z_dw < size_z - DW'(1));
      ctl.vol_end    = z_end && y_end && x_end;
      ctl.last_voxel = (x_dw == size_x - DW'(1)) && (y_dw == size_y - DW'(2)) &&
                       (z_dw == size_z - DW'(2));
   end

   // entries are addressed {y, z}; off-row neighbours wrap, only used for interior voxels
   assign addr_here = {y_ff, z_ff};
   assign addr_next = {ny, nz};
   assign addr_yp   = {y_ff + PW'(1), z_ff};
   assign addr_ym   = {y_ff - PW'(1), z_ff};

   assign x_in = accept ? nx : x_ff;
   assign y_in = accept ? ny : y_ff;
   assign z_in = accept ? nz : z_ff;

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         x_ff <= '0;
         y_ff <= '0;
         z_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign pos_x = x_ff;
   assign pos_y = y_ff;
   assign pos_z = z_ff;

endmodule

// ===== sv/vse_stencil.sv =====
module vse_stencil #(
   parameter int MAX_DIM = vse_pkg::MAX_DIM_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            restart,
   input  logic                            accept,
   output logic                            s1_ready,
   input  logic                            cur,
   input  vse_pkg::scan_ctl_type           ctl,
   input  logic [$clog2(MAX_DIM)-1:0]      pos_x,
   input  logic [$clog2(MAX_DIM)-1:0]      pos_y,
   input  logic [$clog2(MAX_DIM)-1:0]      pos_z,
   input  logic [2*$clog2(MAX_DIM)-1:0]    addr_here,
   input  logic                            hi_zp,
   input  logic                            hi_yp,
   input  logic                            lo_old,
   input  logic                            lo_ym,
   output logic                            wr_en,
   output logic [2*$clog2(MAX_DIM)-1:0]    wr_addr,
   output logic                            hi_wdata,
   output logic                            lo_wdata,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            is_surface,
   output logic [vse_pkg::POS_W-1:0]       out_x,
   output logic [vse_pkg::POS_W-1:0]       out_y,
   output logic [vse_pkg::POS_W-1:0]       out_z,
   output logic [vse_pkg::COUNT_W-1:0]     surface_count,
   output logic                            end_of_volume
);

   import vse_pkg::*;

   localparam int PW = $clog2(MAX_DIM);
   localparam int AW = 2*PW;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_cur_ff;
   scan_ctl_type       s1_ctl_ff;
   logic [PW-1:0]      s1_x_ff, s1_y_ff, s1_z_ff;
   logic [AW-1:0]      s1_addr_ff;
   logic               ctr_ff;       // center bit, newer plane
   logic               zm_ff;        // z-1 neighbour, newer plane
   logic [COUNT_W-1:0] total_ff, total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               surf_ff;
   logic [POS_W-1:0]   rx_ff, ry_ff, rz_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic               eov_ff;
   logic               s1_advance;
   logic               empty_nb;
   logic               surf;
   logic [COUNT_W-1:0] count_new;
   logic               load_rsp;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_ready   = !s1_valid_ff || s1_advance;
   assign load_rsp   = s1_advance && s1_ctl_ff.judge;

   assign empty_nb  = !s1_cur_ff || !lo_old || !hi_zp || !zm_ff || !hi_yp || !lo_ym;
   assign surf      = s1_ctl_ff.judge && ctr_ff && empty_nb;
   assign count_new = total_ff + COUNT_W'(surf);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      total_in = total_ff;
      if (restart) begin
         total_in = '0;
      end else if (s1_advance) begin
         total_in = s1_ctl_ff.vol_end ? '0 : count_new;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff  <= cur;
         s1_ctl_ff  <= ctl;
         s1_x_ff    <= pos_x;
         s1_y_ff    <= pos_y;
         s1_z_ff    <= pos_z;
         s1_addr_ff <= addr_here;
      end
      if (s1_advance) begin
         ctr_ff <= hi_zp;
         zm_ff  <= ctr_ff;
      end
      if (load_rsp) begin
         surf_ff <= surf;
         rx_ff   <= POS_W'(s1_x_ff - PW'(1));
         ry_ff   <= POS_W'(s1_y_ff);
         rz_ff   <= POS_W'(s1_z_ff);
         cnt_ff  <= count_new;
         eov_ff  <= s1_ctl_ff.last_voxel;
      end
   end

   // arriving bit goes to the newer plane, the old center moves to the older one
   assign wr_en    = s1_advance;
   assign wr_addr  = s1_addr_ff;
   assign hi_wdata = s1_cur_ff;
   assign lo_wdata = ctr_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign is_surface    = surf_ff;
   assign out_x         = rx_ff;
   assign out_y         = ry_ff;
   assign out_z         = rz_ff;
   assign surface_count = cnt_ff;
   assign end_of_volume = eov_ff;

endmodule

// ===== sv/vse_checker.sv =====
`include "voxel_surface_extract_6conn_core_macros.svh"

module vse_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   logic [49:0] rsp_word;

   assign rsp_word = {rsp_tlast, rsp_tuser, rsp_tdata};

   // a stalled result stays offered
   `VSE_ASSERT_NXT(a_rsp_valid_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // and keeps its contents
   `VSE_ASSERT_NXT(a_rsp_data_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_word))

   // a surface voxel is already included in the count it carries
   `VSE_ASSERT_IMP(a_surface_counted, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[41:21] != 21'd0)

   // reset drops any pending result
   `VSE_ASSERT_NXT(a_reset_clears, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind voxel_surface_extract_6conn_core vse_checker u_vse_checker (.*);

// ===== bench/tb_voxel_surface_extract_6conn_core.sv =====
`timescale 1ns / 100ps

// One judged voxel as it leaves the block.
typedef struct packed {
   bit        is_surface;
   bit [6:0]  pos_x;
   bit [6:0]  pos_y;
   bit [6:0]  pos_z;
   bit [20:0] surface_count;
   bit        end_of_volume;
} voxel_verdict_type;

class surface_scoreboard;
   localparam int DIM   = vse_pkg::MAX_DIM_DEFAULT;
   localparam int CELLS = DIM * DIM;

   bit [7:0]          extent_reg [3];
   bit                plane [2][CELLS];   // two x planes, indexed y*DIM+z
   bit                older_sel;
   int unsigned       scan_x, scan_y, scan_z;
   bit [20:0]         surface_total;
   voxel_verdict_type pending_verdicts [$];
   int                mismatches;

   function new();
      foreach (extent_reg[i]) extent_reg[i] = vse_pkg::SIZE_RESET;
      older_sel  = 1'b0;
      mismatches = 0;
      restart_scan();
   endfunction

   function void restart_scan();
      scan_x        = 0;
      scan_y        = 0;
      scan_z        = 0;
      surface_total = '0;
   endfunction

   function int unsigned clamp_extent(int idx);
      if (extent_reg[idx] < 3) return 3;
      if (extent_reg[idx] > DIM) return DIM;
      return extent_reg[idx];
   endfunction

   function int unsigned volume_voxels();
      return clamp_extent(0) * clamp_extent(1) * clamp_extent(2);
   endfunction

   // any register write restarts the scan; plane contents stay
   function void write_extent(vse_pkg::csr_reg_type r, bit [7:0] v);
      extent_reg[int'(r)] = v;
      restart_scan();
   endfunction

   function bit [7:0] read_extent(vse_pkg::csr_reg_type r);
      return extent_reg[int'(r)];
   endfunction

   function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
   endfunction

   function int pending();
      return pending_verdicts.size();
   endfunction

   // Accepted voxel: judge the voxel one plane back if it is interior.
   function void take_voxel(bit occ);
      int unsigned       sx, sy, sz;
      int                here;
      bit                older, newer;
      bit                filled, empty_nb;
      voxel_verdict_type v;
      sx    = clamp_extent(0);
      sy    = clamp_extent(1);
      sz    = clamp_extent(2);
      here  = scan_y * DIM + scan_z;
      older = older_sel;
      newer = !older_sel;
      if (scan_x >= 2 && scan_y >= 1 && scan_y + 1 < sy && scan_z >= 1 && scan_z + 1 < sz) begin
         filled   = plane[newer][here];
         empty_nb = !occ || !plane[older][here] ||
                    !plane[newer][here + 1] || !plane[newer][here - 1] ||
                    !plane[newer][here + DIM] || !plane[newer][here - DIM];
         v.is_surface = filled && empty_nb;
         if (v.is_surface) surface_total = surface_total + 1'b1;
         v.pos_x         = 7'(scan_x - 1);
         v.pos_y         = 7'(scan_y);
         v.pos_z         = 7'(scan_z);
         v.surface_count = surface_total;
         v.end_of_volume = (scan_x + 1 == sx) && (scan_y + 2 == sy) && (scan_z + 2 == sz);
         pending_verdicts.push_back(v);
      end
      // oldest plane entry is dead now, it takes the arriving plane
      plane[older][here] = occ;
      scan_z++;
      if (scan_z >= sz) begin
         scan_z = 0;
         scan_y++;
         if (scan_y >= sy) begin
            scan_y    = 0;
            older_sel = !older_sel;
            scan_x++;
            if (scan_x >= sx) begin
               scan_x        = 0;
               surface_total = '0;
            end
         end
      end
   endfunction

   function void compare_field(string name, int unsigned want_v, int unsigned got_v,
                               voxel_verdict_type want);
      if (want_v != got_v)
         flag($sformatf("%s at (%0d,%0d,%0d): expected %0d, got %0d", name,
                        want.pos_x, want.pos_y, want.pos_z, want_v, got_v));
   endfunction

   function void check_verdict(voxel_verdict_type got);
      voxel_verdict_type want;
      if (pending_verdicts.size() == 0) begin
         flag($sformatf("result (%0d,%0d,%0d) with no request awaiting it",
                        got.pos_x, got.pos_y, got.pos_z));
         return;
      end
      want = pending_verdicts.pop_front();
      compare_field("is_surface", want.is_surface, got.is_surface, want);
      compare_field("pos_x", want.pos_x, got.pos_x, want);
      compare_field("pos_y", want.pos_y, got.pos_y, want);
      compare_field("pos_z", want.pos_z, got.pos_z, want);
      compare_field("surface_count", want.surface_count, got.surface_count, want);
      compare_field("end_of_volume", want.end_of_volume, got.end_of_volume, want);
   endfunction
endclass

module tb_voxel_surface_extract_6conn_core;
   import vse_pkg::*;

   localparam int CYCLE_LIMIT      = 500_000;
   localparam int SETTLE_CYCLES    = 8;     // margin after the last expected result
   localparam int TAIL_CYCLES      = 16;
   localparam int HOLDOFF_CYCLES   = 250;   // long enough to back the pipe up into req
   localparam int PHASE_REQUESTS   = 70;    // random requests per idling phase
   localparam int EXTREME_REQUESTS = 45;    // first planes of a saturated-extent volume

   // first byte address past the register map, writes there are dropped
   localparam logic [CSR_AW-1:0] CSR_ADDR_UNMAPPED = 4'hC;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_tvalid  = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata   = '0;
   logic               rsp_tvalid;
   logic               rsp_tready  = 1'b0;
   logic [47:0]        rsp_tdata;
   logic               rsp_tuser;
   logic               rsp_tlast;
   logic               csr_psel    = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]  csr_paddr   = '0;
   logic [CSR_DW-1:0]  csr_pwdata  = '0;
   logic [CSR_DW-1:0]  csr_prdata;
   logic               csr_pready;

   // idling knobs, percent per cycle
   int unsigned req_idle_pct  = 0;
   int unsigned rsp_stall_pct = 0;

   // long receiver hold-off: asked for by the stimulus, timed by the receiver
   bit want_holdoff = 1'b0;
   bit holdoff_done = 1'b0;
   int holdoff_left = 0;

   int cycle_count = 0;

   surface_scoreboard sb = new();

   always #6 clock = ~clock;

   voxel_surface_extract_6conn_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off when asked.
   always @(negedge clock) begin
      if (want_holdoff && !holdoff_done) begin
         holdoff_left = HOLDOFF_CYCLES;
         holdoff_done = 1'b1;
      end
      if (holdoff_left > 0) begin
         holdoff_left = holdoff_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Monitor: both channels sampled at the rising edge.
   always @(posedge clock) begin
      voxel_verdict_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.is_surface    = rsp_tuser;
            got.pos_x         = rsp_tdata[6:0];
            got.pos_y         = rsp_tdata[13:7];
            got.pos_z         = rsp_tdata[20:14];
            got.surface_count = rsp_tdata[41:21];
            got.end_of_volume = rsp_tlast;
            sb.check_verdict(got);
         end
         if (req_tvalid && req_tready) sb.take_voxel(req_tdata[0]);
      end
   end

   // All driver tasks start and end just after a falling edge.

   // One occupancy request; valid stays up afterward so bursts run back to back.
   task automatic send_voxel(input bit occ);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, occ};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic stream_voxels(input int unsigned n, input int unsigned fill_pct);
      for (int unsigned i = 0; i < n; i++) send_voxel($urandom_range(99) < fill_pct);
      end_burst();
   endtask

   // Idle point: every expected result back, then let requests with no result retire.
   task automatic drain();
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr[3:2] <= REG_SIZE_Z) sb.write_extent(csr_reg_type'(addr[3:2]), data[7:0]);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_check(input csr_reg_type r);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {r, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[7:0] !== sb.read_extent(r))
         sb.flag($sformatf("register %s read %0d, expected %0d", r.name(),
                           csr_prdata[7:0], sb.read_extent(r)));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // New volume shape; upper data bits are junk the block must drop.
   task automatic program_extents(input bit [7:0] ex, input bit [7:0] ey, input bit [7:0] ez);
      drain();
      csr_write({REG_SIZE_X, 2'b00}, {24'($urandom), ex});
      csr_write({REG_SIZE_Y, 2'b00}, {24'($urandom), ey});
      csr_write({REG_SIZE_Z, 2'b00}, {24'($urandom), ez});
      csr_check(REG_SIZE_X);
      csr_check(REG_SIZE_Y);
      csr_check(REG_SIZE_Z);
   endtask

   // Mostly tiny volumes; now and then an extent below 3, which saturates.
   function automatic bit [7:0] pick_extent();
      if ($urandom_range(9) == 0) return 8'($urandom_range(2));
      return 8'($urandom_range(6, 3));
   endfunction

   function automatic int unsigned pick_fill();
      case ($urandom_range(5))
         0:       return 0;
         1:       return 40;
         2:       return 75;
         3:       return 90;
         4:       return 97;
         default: return 100;
      endcase
   endfunction

   initial begin
      int unsigned n;
      int unsigned vol;
      int unsigned phase_requests;
      bit          prev_cut;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed ----
      // reset extents read back as 128
      csr_check(REG_SIZE_X);
      csr_check(REG_SIZE_Y);
      csr_check(REG_SIZE_Z);

      // a few voxels into a 128^3 volume, then a write restarts the scan
      for (int i = 0; i < 5; i++) send_voxel(bit'(i & 1));
      end_burst();

      // extents below 3 all saturate: 3x3x3 volume, one interior voxel
      program_extents(8'd2, 8'd1, 8'd0);

      // write past the register map mid-volume must not restart the scan
      stream_voxels(10, 100);
      drain();
      csr_write(CSR_ADDR_UNMAPPED, 32'h0000_0005);
      stream_voxels(17, 100);   // solid cube: center is interior, not surface

      // ---- idling phases: extreme extents, then random volumes ----
      prev_cut = 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin req_idle_pct = 75; rsp_stall_pct = 0;  end
            2:       begin req_idle_pct = 0;  rsp_stall_pct = 75; end
            default: begin req_idle_pct = 33; rsp_stall_pct = 33; end
         endcase

         case (phase)
            0: begin
               // receiver holds off while the sender keeps pushing
               program_extents(8'd5, 8'd5, 8'd5);
               want_holdoff = 1'b1;
               stream_voxels(sb.volume_voxels(), 75);
            end
            1: begin
               program_extents(8'd200, 8'd3, 8'd3);   // saturates to 128
               stream_voxels(EXTREME_REQUESTS, 90);
               prev_cut = 1'b1;
            end
            2: begin
               program_extents(8'd255, 8'd3, 8'd4);   // saturates to 128
               stream_voxels(EXTREME_REQUESTS, 90);
               prev_cut = 1'b1;
            end
            default: ;
         endcase

         phase_requests = 0;
         while (phase_requests < PHASE_REQUESTS) begin
            // a finished volume may roll straight into the next one
            if (prev_cut || $urandom_range(99) >= 30)
               program_extents(pick_extent(), pick_extent(), pick_extent());
            vol      = sb.volume_voxels();
            n        = vol;
            prev_cut = 1'b0;
            if ($urandom_range(99) < 15) begin
               n        = $urandom_range(vol - 1, 1);
               prev_cut = 1'b1;
            end
            stream_voxels(n, pick_fill());
            phase_requests += n;
         end
      end

      // ---- wind down ----
      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.pending() != 0)
         sb.flag($sformatf("%0d results never arrived", sb.pending()));
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/vse_pkg.sv
sv/vse_plane_mem.sv
sv/vse_csr.sv
sv/vse_scan.sv
sv/vse_stencil.sv
sv/voxel_surface_extract_6conn_core.sv
sv/vse_checker.sv
bench/tb_voxel_surface_extract_6conn_core.sv
